@@ rtl/pgw_pkg.sv @@
// Shared types and constants for the four-level page table walker.
// Used by four_level_page_table_walker and the testbench; no dependencies.
package pgw_pkg;

  localparam int unsigned PA_W     = 52;
  localparam int unsigned OFF_W    = 12;
  localparam int unsigned IDX_W    = 9;
  localparam int unsigned ENT_SH   = 3;   // eight bytes per table entry
  localparam int unsigned LEVEL_W  = 2;

  localparam logic [LEVEL_W-1:0] LAST_LEVEL = 2'd3;

  typedef enum logic [1:0] {
    ST_TRANSLATED = 2'd0,
    ST_FAULT      = 2'd1,
    ST_STORED     = 2'd2,
    ST_DROPPED    = 2'd3
  } status_t;

  typedef enum logic {
    OP_STORE     = 1'b0,
    OP_TRANSLATE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_FIN
  } state_t;

endpackage

@@ rtl/pgw_store.sv @@
// Entry memory of the walker: address and word arrays, one write and one
// registered read port. Depends on nothing.
module pgw_store #(
  parameter int unsigned AW = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_idx,
  input  logic [63:0]   wr_addr,
  input  logic [63:0]   wr_word,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_idx,
  output logic [63:0]   rd_addr,
  output logic [63:0]   rd_word
);

  logic [63:0] addr_mem [2**AW];
  logic [63:0] word_mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      addr_mem[wr_idx] <= wr_addr;
      word_mem[wr_idx] <= wr_word;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr <= addr_mem[rd_idx];
      rd_word <= word_mem[rd_idx];
    end
  end

endmodule

@@ rtl/four_level_page_table_walker.sv @@
// Four-level page table walker over an associative entry memory.
// Each lookup scans the filled entries, reading and then comparing each one;
// a store scans the memory once and a translate up to once per level,
// four times in all; one request is in work at a time.
// Reset (rst_n low, synchronous) empties the memory via the fill count,
// clears the root base and drops any pending result.
module four_level_page_table_walker
  import pgw_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wen,
  input  logic [63:0]  cfg_wdata,       // root_table_base
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,        // [63:0] address, [127:64] word
  input  logic         in_tuser,        // operation
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [55:0]  out_tdata,       // [51:0] physical_address, [55:52] zero
  output logic [1:0]   out_tuser        // status
);

  localparam int unsigned AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_ENTRIES);

  state_t state_r, state_nxt;
  logic [63:0]         root_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    ptr_r, ptr_nxt;
  logic [LEVEL_W-1:0]  level_r, level_nxt;
  logic                op_r, op_nxt;
  logic [63:0]         vaddr_r, vaddr_nxt;
  logic [63:0]         word_r, word_nxt;
  logic [63:0]         look_r, look_nxt;
  logic [PA_W-1:0]     pa_r, pa_nxt;
  status_t             stat_r, stat_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PA_W-1:0]     out_pa_r, out_pa_nxt;
  status_t             out_stat_r, out_stat_nxt;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_idx;
  logic [63:0]   rd_addr, rd_word;
  logic [63:0]   frame;
  logic [IDX_W-1:0] idx_first, idx_next;

  pgw_store #(.AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_addr (look_r),
    .wr_word (word_r),
    .rd_en   (rd_en),
    .rd_idx  (ptr_r[AW-1:0]),
    .rd_addr (rd_addr),
    .rd_word (rd_word)
  );

  // table indices: top level from the incoming request, next level from level_r
  assign idx_first = in_tdata[47:39];
  always_comb begin
    unique case (level_r)
      2'd0:    idx_next = vaddr_r[38:30];
      2'd1:    idx_next = vaddr_r[29:21];
      default: idx_next = vaddr_r[20:12];
    endcase
  end

  assign frame = {12'd0, rd_word[51:OFF_W], {OFF_W{1'b0}}};

  // request control
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    level_nxt     = level_r;
    op_nxt        = op_r;
    vaddr_nxt     = vaddr_r;
    word_nxt      = word_r;
    look_nxt      = look_r;
    pa_nxt        = pa_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r;
    out_pa_nxt    = out_pa_r;
    out_stat_nxt  = out_stat_r;
    wr_en         = 1'b0;
    wr_idx        = ptr_r[AW-1:0];
    rd_en         = 1'b0;
    in_tready     = (state_r == S_IDLE);

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          vaddr_nxt = in_tdata[63:0];
          word_nxt  = in_tdata[127:64];
          level_nxt = '0;
          ptr_nxt   = '0;
          if (in_tuser == OP_STORE) look_nxt = in_tdata[63:0];
          else look_nxt = root_r + {52'd0, idx_first, {ENT_SH{1'b0}}};
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (ptr_r == count_r) begin
          // no match among filled entries
          pa_nxt    = '0;
          state_nxt = S_FIN;
          if (op_r == OP_TRANSLATE) stat_nxt = ST_FAULT;
          else if (count_r == FULL) stat_nxt = ST_DROPPED;
          else begin
            wr_en     = 1'b1;
            wr_idx    = count_r[AW-1:0];
            count_nxt = count_r + 1'b1;
            stat_nxt  = ST_STORED;
          end
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_addr == look_r) begin
          if (op_r == OP_STORE) begin
            // overwrite the matching entry
            wr_en     = 1'b1;
            pa_nxt    = '0;
            stat_nxt  = ST_STORED;
            state_nxt = S_FIN;
          end else if (!rd_word[0]) begin
            pa_nxt    = '0;
            stat_nxt  = ST_FAULT;
            state_nxt = S_FIN;
          end else if (level_r == LAST_LEVEL) begin
            pa_nxt    = {rd_word[51:OFF_W], vaddr_r[OFF_W-1:0]};
            stat_nxt  = ST_TRANSLATED;
            state_nxt = S_FIN;
          end else begin
            // descend one level
            look_nxt  = frame + {52'd0, idx_next, {ENT_SH{1'b0}}};
            level_nxt = level_r + 1'b1;
            ptr_nxt   = '0;
            state_nxt = S_READ;
          end
        end else begin
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = S_READ;
        end
      end
      S_FIN: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_pa_nxt    = pa_r;
          out_stat_nxt  = stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      root_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) root_r <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    level_r    <= level_nxt;
    op_r       <= op_nxt;
    vaddr_r    <= vaddr_nxt;
    word_r     <= word_nxt;
    look_r     <= look_nxt;
    pa_r       <= pa_nxt;
    stat_r     <= stat_nxt;
    out_pa_r   <= out_pa_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_pa_r};
  assign out_tuser  = out_stat_r;

endmodule

@@ tb/sv/tb_four_level_page_table_walker.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the four-level page table walker: stores build page
// tables, translates walk them; results are checked against a local predictor.
// Depends on pgw_pkg and four_level_page_table_walker.
module tb_four_level_page_table_walker;
  import pgw_pkg::*;

  localparam int unsigned SLOTS = 256;
  localparam int unsigned IDLE_LIMIT = 200000;

  typedef struct packed {
    logic [51:0] pa;
    status_t     st;
  } walk_result_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_wen;
  logic [63:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // [63:0] address, [127:64] word
  logic         in_tuser;   // operation
  logic         out_tvalid;
  logic         out_tready;
  logic [55:0]  out_tdata;  // [51:0] physical_address, [55:52] zero
  logic [1:0]   out_tuser;  // status

  // Predictor state: copy of the associative memory and the root base
  logic [63:0]  mem_addr [SLOTS];
  logic [63:0]  mem_word [SLOTS];
  logic         mem_used [SLOTS];
  logic [63:0]  root_base;

  walk_result_t expected_q[$];
  int           fail_count;
  int           idle_cycles;
  bit           stall_mode;
  int           burst_left;

  four_level_page_table_walker u_top (
    .clk(clk), .rst_n(rst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int find_entry(input logic [63:0] a);
    for (int i = 0; i < SLOTS; i++)
      if (mem_used[i] && mem_addr[i] == a) return i;
    return -1;
  endfunction

  // Update the memory copy and work out the result of one request
  function automatic walk_result_t predict_walk(input op_t op, input logic [63:0] a,
                                                input logic [63:0] w);
    walk_result_t r;
    int s;
    logic [63:0] base;
    logic [63:0] look;
    r.pa = '0;
    if (op == OP_STORE) begin
      s = find_entry(a);
      if (s < 0)
        for (int i = 0; i < SLOTS; i++)
          if (!mem_used[i]) begin s = i; break; end
      if (s < 0) begin
        r.st = ST_DROPPED;
      end else begin
        mem_addr[s] = a; mem_word[s] = w; mem_used[s] = 1'b1;
        r.st = ST_STORED;
      end
      return r;
    end
    base = root_base;
    for (int lvl = 0; lvl < 4; lvl++) begin
      look = base + {52'd0, a[47-9*lvl -: 9], 3'd0};
      s = find_entry(look);
      if (s < 0 || !mem_word[s][0]) begin
        r.st = ST_FAULT;
        return r;
      end
      base = {12'd0, mem_word[s][51:12], 12'd0};
    end
    r.pa = base[51:0] + {40'd0, a[11:0]};
    r.st = ST_TRANSLATED;
    return r;
  endfunction

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    walk_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result pa=%h st=%0d", $time, out_tdata[51:0], out_tuser);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (out_tdata[51:0] !== e.pa) begin
          $display("%0t: pa expected %h actual %h", $time, e.pa, out_tdata[51:0]);
          fail_count++;
        end
        if (out_tdata[55:52] !== 4'd0) begin
          $display("%0t: pad expected 0 actual %h", $time, out_tdata[55:52]);
          fail_count++;
        end
        if (out_tuser !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // Receiver: stall on a pattern of its own, with calm stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_mode = !stall_mode;
    out_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_four_level_page_table_walker failed");
      $finish;
    end
  end

  // Send one request; gaps come between bursts of random length
  task automatic send_request(input op_t op, input logic [63:0] a, input logic [63:0] w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (in_tvalid) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
        gap--;
      end
      repeat (gap > 0 ? gap : 0) @(negedge clk);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {w, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(predict_walk(op, a, w));
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_root(input logic [63:0] v);
    drain();
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen <= 1'b0;
    root_base = v;
  endtask

  // Build a full walk for linear address la under the current root
  task automatic map_page(input logic [63:0] la, input logic [39:0] frame,
                          input logic [63:0] hi_bits);
    logic [63:0] base;
    logic [63:0] w;
    base = root_base;
    for (int lvl = 0; lvl < 4; lvl++) begin
      w = (hi_bits & ~64'h000F_FFFF_FFFF_F000) | 64'h1;
      w[51:12] = (lvl == 3) ? frame : 40'({$urandom, $urandom});
      if ($urandom_range(0, 3) == 0) w[51:12] = w[51:12] & 40'hF;
      send_request(OP_STORE, base + {52'd0, la[47-9*lvl -: 9], 3'd0}, w);
      base = {12'd0, w[51:12], 12'd0};
    end
  endtask

  task automatic test_directed;
    write_root(64'd0);
    send_request(OP_TRANSLATE, 64'd0, 64'd0);            // empty memory faults
    map_page(64'h0000_0000_0000_0FFF, 40'hFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_TRANSLATE, 64'hFFFF_0000_0000_0FFF, '1);  // upper bits ignored
    send_request(OP_TRANSLATE, 64'h0000_0000_0000_0000, '0);
    map_page(64'h0000_FFFF_FFFF_F000, 40'd0, 64'd0);
    send_request(OP_TRANSLATE, 64'h0000_FFFF_FFFF_FABC, '0);
    send_request(OP_STORE, 64'd0, 64'hFFFF_FFFF_FFFF_FFFE);  // overwrite, not present
    send_request(OP_TRANSLATE, 64'h0, '0);
    send_request(OP_STORE, '1, '1);
    send_request(OP_STORE, '1, 64'h0);
    // Root near the top wraps the first sum
    write_root(64'hFFFF_FFFF_FFFF_FFF8);
    send_request(OP_STORE, 64'h0, 64'h1);
    send_request(OP_TRANSLATE, 64'h0000_0080_0000_0000, '0);
  endtask

  task automatic test_fill_table;
    write_root(64'h1000);
    // Fill every slot, then see stores dropped and existing ones still updated
    for (int i = 0; i < SLOTS + 4; i++)
      send_request(OP_STORE, 64'h8000_0000 + i * 8, {$urandom, $urandom});
    send_request(OP_STORE, 64'h8000_0000, 64'h1);
    send_request(OP_TRANSLATE, {$urandom, $urandom}, '0);
  endtask

  task automatic test_random_walks(input int count, input logic [63:0] root);
    logic [63:0] las[$];
    logic [63:0] la;
    write_root(root);
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          la = {$urandom, $urandom};
          if (las.size() != 0 && $urandom_range(0, 1)) la[47:21] = las[0][47:21];
          map_page(la, 40'({$urandom, $urandom}), {$urandom, $urandom});
          las.push_front(la);
          n += 3;
        end
        3: send_request(OP_STORE, {$urandom, $urandom}, {$urandom, $urandom});
        4: send_request(OP_TRANSLATE, {$urandom, $urandom}, {$urandom, $urandom});
        default: begin
          la = (las.size() != 0) ? las[$urandom_range(0, las.size() - 1)] : 64'd0;
          la[11:0] = 12'($urandom);
          la[63:48] = 16'($urandom);
          if ($urandom_range(0, 5) == 0) la[$urandom_range(12, 47)] ^= 1'b1;
          send_request(OP_TRANSLATE, la, {$urandom, $urandom});
        end
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0; cfg_wen = 1'b0; cfg_wdata = '0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0; out_tready = 1'b0;
    fail_count = 0; idle_cycles = 0; stall_mode = 1'b0; burst_left = 0;
    root_base = '0;
    for (int i = 0; i < SLOTS; i++) begin
      mem_used[i] = 1'b0; mem_addr[i] = '0; mem_word[i] = '0;
    end
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_walks(700, {$urandom, $urandom} & 64'h000F_FFFF_FFFF_F000);
    test_fill_table();
    test_random_walks(600, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();
    if (fail_count == 0) $display("tb_four_level_page_table_walker passed");
    else $display("tb_four_level_page_table_walker failed");
    $finish;
  end

endmodule

@@ four_level_page_table_walker.f @@
rtl/pgw_pkg.sv
rtl/pgw_store.sv
rtl/four_level_page_table_walker.sv
tb/sv/tb_four_level_page_table_walker.sv
